@@ sv/mfr_pkg.sv @@
// ----------------------------------------------------------------------------
// mfr_pkg: shared types and constants
// Word formats, codes and defaults of the flood relay filter.
// ----------------------------------------------------------------------------
package mfr_pkg;

    localparam logic [31:0] BROADCAST_ID = 32'hFFFF_FFFF;
    localparam logic [7:0]  ACK_TTL      = 8'd30;
    localparam int          MS_PER_S     = 1000;
    localparam logic [7:0]  TYPE_ACK     = 8'd2;
    localparam logic [7:0]  TYPE_NACK    = 8'd3;

    localparam int SEEN_DEPTH_DEF  = 64;
    localparam int ROUTE_DEPTH_DEF = 32;
    localparam int INQ_DEPTH       = 2;
    localparam int OUTQ_DEPTH      = 4;

    // (ttl + 1) * 1000 fits in 18 bits
    localparam int AGE_W = 18;

    localparam logic [31:0] DEVICE_ID_RST    = 32'd0;
    localparam logic [7:0]  MAX_HOPS_RST     = 8'd5;
    localparam logic [31:0] MAX_AGE_MS_RST   = 32'd300000;
    localparam logic [1:0]  ACK_PRIORITY_RST = 2'd2;

    typedef enum logic [1:0] {
        ACT_RECV  = 2'd0,
        ACT_OWN   = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_CLEAN = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_DELIVER = 3'd0,
        KIND_ACK     = 3'd1,
        KIND_RELAY   = 3'd2,
        KIND_OWN     = 3'd3,
        KIND_STATUS  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        REG_DEVICE_ID    = 2'd0,
        REG_MAX_HOPS     = 2'd1,
        REG_MAX_AGE_MS   = 2'd2,
        REG_ACK_PRIORITY = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] device_id;
        logic [7:0]  max_hops;
        logic [31:0] max_age_ms;
        logic [1:0]  ack_priority;
    } cfg_t;

    typedef struct packed {
        action_t     action;
        logic [31:0] source;
        logic [31:0] dest;
        logic [31:0] seq;
        logic [7:0]  mtype;
        logic [1:0]  prio;
        logic [7:0]  hops;
        logic [7:0]  ttl;
        logic [31:0] ts;
    } hdr_t;

    // classified word passed from front to back
    typedef struct packed {
        hdr_t             hdr;
        logic             for_us;
        logic             ack_req;
        logic             relay_ok;
        logic [AGE_W-1:0] age_lim;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] source;
        logic [31:0] dest;
        logic [31:0] seq;
        logic [7:0]  mtype;
        logic [1:0]  prio;
        logic [7:0]  hops;
        logic [7:0]  ttl;
        logic [31:0] time_ms;
        logic [31:0] acked;
    } res_t;

endpackage

@@ sv/mfr_ram.sv @@
// ----------------------------------------------------------------------------
// mfr_ram: generic single-write, single-read RAM
// Registered read data, no reset on contents.
// ----------------------------------------------------------------------------
module mfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/mfr_fifo.sv @@
// ----------------------------------------------------------------------------
// mfr_fifo: small register queue
// Push/full on the write side, pop/empty on the read side.
// ----------------------------------------------------------------------------
module mfr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0]   LAST  = AW'(DEPTH - 1);
    localparam logic [CNTW-1:0] CFULL = CNTW'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CFULL);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNTW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

@@ sv/mfr_front.sv @@
// ----------------------------------------------------------------------------
// mfr_front: input acceptance and classification
// Decodes addressing, static relay rules and the TTL age limit, then queues.
// ----------------------------------------------------------------------------
module mfr_front (
    input  logic           clk,
    input  logic           rst_n,
    input  mfr_pkg::cfg_t  cfg,
    input  logic           push,
    input  mfr_pkg::hdr_t  hdr,
    output logic           full,
    input  logic           q_pop,
    output mfr_pkg::item_t q_item,
    output logic           q_empty
);

    mfr_pkg::item_t item;
    logic           is_bcast;
    logic           to_me;

    always_comb
    begin
        is_bcast      = (hdr.dest == mfr_pkg::BROADCAST_ID);
        to_me         = (hdr.dest == cfg.device_id);
        item.hdr      = hdr;
        item.for_us   = to_me || is_bcast;
        item.ack_req  = to_me && !is_bcast;
        item.relay_ok = (hdr.hops < cfg.max_hops) && item.for_us &&
                        !(hdr.mtype inside {mfr_pkg::TYPE_ACK, mfr_pkg::TYPE_NACK});
        // floor(age / 1000) > ttl  <=>  age >= (ttl + 1) * 1000
        item.age_lim  = mfr_pkg::AGE_W'((mfr_pkg::AGE_W'(hdr.ttl) + mfr_pkg::AGE_W'(1)) *
                                        mfr_pkg::AGE_W'(mfr_pkg::MS_PER_S));
    end

    mfr_fifo #(
        .WIDTH ($bits(mfr_pkg::item_t)),
        .DEPTH (mfr_pkg::INQ_DEPTH)
    ) u_inq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (item),
        .full  (full),
        .pop   (q_pop),
        .dout  (q_item),
        .empty (q_empty)
    );

endmodule

@@ sv/mfr_back.sv @@
// ----------------------------------------------------------------------------
// mfr_back: table sequencer and result generation
// Sweeps the seen and route tables, updates them and queues results.
// ----------------------------------------------------------------------------
module mfr_back #(
    parameter int SEEN_DEPTH  = mfr_pkg::SEEN_DEPTH_DEF,
    parameter int ROUTE_DEPTH = mfr_pkg::ROUTE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mfr_pkg::cfg_t                    cfg,
    input  mfr_pkg::item_t                   q_item,
    input  logic                             q_empty,
    output logic                             q_pop,
    input  logic                             res_pop,
    output logic                             res_empty,
    output mfr_pkg::res_t                    res_word,
    output logic [$clog2(ROUTE_DEPTH+1)-1:0] res_rc,
    output logic                             res_last
);

    localparam int SIW = $clog2(SEEN_DEPTH);
    localparam int RIW = $clog2(ROUTE_DEPTH);
    localparam int CW  = (SIW > RIW) ? SIW : RIW;
    localparam int RCW = $clog2(ROUTE_DEPTH + 1);
    localparam int RW  = $bits(mfr_pkg::res_t);
    localparam logic [CW-1:0]  SEEN_LAST  = CW'(SEEN_DEPTH - 1);
    localparam logic [CW-1:0]  ROUTE_LAST = CW'(ROUTE_DEPTH - 1);
    localparam logic [SIW-1:0] SVIC_LAST  = SIW'(SEEN_DEPTH - 1);
    localparam logic [RIW-1:0] RVIC_LAST  = RIW'(ROUTE_DEPTH - 1);

    localparam int P_DELIVER = 0;
    localparam int P_ACK     = 1;
    localparam int P_RELAY   = 2;
    localparam int P_OWN     = 3;
    localparam int P_STATUS  = 4;

    typedef enum logic [5:0] {
        ST_IDLE        = 6'b000001,
        ST_SEEN_SWEEP  = 6'b000010,
        ST_SEEN_WR     = 6'b000100,
        ST_ROUTE_SWEEP = 6'b001000,
        ST_ROUTE_WR    = 6'b010000,
        ST_EMIT        = 6'b100000
    } state_t;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_ACK   = 2'd1,
        PH_RELAY = 2'd2
    } phase_t;

    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [4:0]             pend_reg, pend_next;
    logic                   clean_reg, clean_next;
    logic [31:0]            lseq_reg, lseq_next;
    logic [31:0]            now_reg, now_next;
    logic [SEEN_DEPTH-1:0]  svalid_reg, svalid_next;
    logic [ROUTE_DEPTH-1:0] rvalid_reg, rvalid_next;
    logic [RCW-1:0]         rcount_reg, rcount_next;
    logic [SIW-1:0]         svic_reg, svic_next;
    logic [RIW-1:0]         rvic_reg, rvic_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          idx_d_reg, idx_d_next;
    logic                   chk_reg, chk_next;
    logic                   hit_reg, hit_next;
    logic [CW-1:0]          hit_idx_reg, hit_idx_next;
    logic                   free_reg, free_next;
    logic [CW-1:0]          free_idx_reg, free_idx_next;
    mfr_pkg::item_t         cur_reg, cur_next;
    logic [31:0]            key_reg, key_next;
    logic [31:0]            oseq_reg, oseq_next;

    logic [63:0]    s_rdata;
    logic [71:0]    r_rdata;
    logic           s_we, r_we;
    logic [SIW-1:0] s_waddr;
    logic [RIW-1:0] r_waddr;
    logic           in_seen;
    logic [CW-1:0]  end_idx;
    logic           e_valid, e_match, e_old;
    logic [31:0]    e_time;
    logic [31:0]    rx_age;
    logic           oq_push, oq_full;
    logic           res_is_last;
    mfr_pkg::res_t  res_new;
    logic [RW+RCW:0] oq_din, oq_dout;

    mfr_ram #(.WIDTH(64), .DEPTH(SEEN_DEPTH)) u_seen_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata ({key_reg, now_reg}),
        .raddr (cnt_reg[SIW-1:0]),
        .rdata (s_rdata)
    );

    mfr_ram #(.WIDTH(72), .DEPTH(ROUTE_DEPTH)) u_route_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata ({cur_reg.hdr.source, cur_reg.hdr.hops, now_reg}),
        .raddr (cnt_reg[RIW-1:0]),
        .rdata (r_rdata)
    );

    assign s_waddr = hit_reg ? hit_idx_reg[SIW-1:0] :
                     free_reg ? free_idx_reg[SIW-1:0] : svic_reg;
    assign r_waddr = hit_reg ? hit_idx_reg[RIW-1:0] :
                     free_reg ? free_idx_reg[RIW-1:0] : rvic_reg;

    // entry under test in the sweep: the read address of the previous cycle
    assign in_seen = (state_reg == ST_SEEN_SWEEP);
    assign end_idx = in_seen ? SEEN_LAST : ROUTE_LAST;
    assign e_valid = in_seen ? svalid_reg[idx_d_reg[SIW-1:0]] : rvalid_reg[idx_d_reg[RIW-1:0]];
    assign e_match = e_valid && (in_seen ? (s_rdata[63:32] == key_reg)
                                         : (r_rdata[71:40] == cur_reg.hdr.source));
    assign e_time  = in_seen ? s_rdata[31:0] : r_rdata[31:0];
    assign e_old   = (now_reg - e_time) > cfg.max_age_ms;
    assign rx_age  = now_reg - q_item.hdr.ts;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        pend_next     = pend_reg;
        clean_next    = clean_reg;
        lseq_next     = lseq_reg;
        now_next      = now_reg;
        svalid_next   = svalid_reg;
        rvalid_next   = rvalid_reg;
        rcount_next   = rcount_reg;
        svic_next     = svic_reg;
        rvic_next     = rvic_reg;
        cnt_next      = '0;
        idx_d_next    = idx_d_reg;
        chk_next      = 1'b0;
        hit_next      = 1'b0;
        hit_idx_next  = hit_idx_reg;
        free_next     = 1'b0;
        free_idx_next = free_idx_reg;
        cur_next      = cur_reg;
        key_next      = key_reg;
        oseq_next     = oseq_reg;
        q_pop         = 1'b0;
        s_we          = 1'b0;
        r_we          = 1'b0;
        oq_push       = 1'b0;
        res_new       = '0;
        res_is_last   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_item;
                    clean_next = 1'b0;
                    phase_next = PH_FIRST;
                    case (q_item.hdr.action)
                        mfr_pkg::ACT_TICK:
                        begin
                            now_next = now_reg + 32'd1;
                        end
                        mfr_pkg::ACT_CLEAN:
                        begin
                            clean_next = 1'b1;
                            pend_next  = 5'(1 << P_STATUS);
                            state_next = ST_ROUTE_SWEEP;
                        end
                        mfr_pkg::ACT_OWN:
                        begin
                            key_next   = lseq_reg;
                            oseq_next  = lseq_reg;
                            lseq_next  = lseq_reg + 32'd1;
                            pend_next  = 5'(1 << P_OWN);
                            state_next = ST_SEEN_SWEEP;
                        end
                        default:
                        begin
                            key_next            = q_item.hdr.seq;
                            pend_next           = '0;
                            pend_next[P_DELIVER] = q_item.for_us;
                            pend_next[P_ACK]     = q_item.ack_req;
                            pend_next[P_RELAY]   = q_item.relay_ok &&
                                                   (rx_age < 32'(q_item.age_lim));
                            pend_next[P_STATUS]  = !q_item.for_us && !pend_next[P_RELAY];
                            state_next          = ST_SEEN_SWEEP;
                        end
                    endcase
                end
            end

            ST_SEEN_SWEEP, ST_ROUTE_SWEEP:
            begin
                cnt_next      = (cnt_reg == end_idx) ? cnt_reg : cnt_reg + CW'(1);
                chk_next      = 1'b1;
                idx_d_next    = cnt_reg;
                hit_next      = hit_reg;
                free_next     = free_reg;
                if (chk_reg)
                begin
                    if (e_match && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = idx_d_reg;
                    end
                    if (!e_valid && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = idx_d_reg;
                    end
                    if (clean_reg && e_valid && e_old)
                    begin
                        if (in_seen)
                        begin
                            svalid_next[idx_d_reg[SIW-1:0]] = 1'b0;
                        end
                        else
                        begin
                            rvalid_next[idx_d_reg[RIW-1:0]] = 1'b0;
                            rcount_next = rcount_reg - RCW'(1);
                        end
                    end
                    if (idx_d_reg == end_idx)
                    begin
                        if (clean_reg)
                        begin
                            // route pass done: seen pass next; seen pass done: report
                            state_next = in_seen ? ST_EMIT : ST_SEEN_SWEEP;
                            cnt_next   = '0;
                            chk_next   = 1'b0;
                        end
                        else
                        begin
                            state_next = in_seen ? ST_SEEN_WR : ST_ROUTE_WR;
                        end
                    end
                end
            end

            ST_SEEN_WR:
            begin
                if (phase_reg == PH_FIRST && cur_reg.hdr.action == mfr_pkg::ACT_RECV &&
                    hit_reg)
                begin
                    // duplicate: no state change, one status word
                    pend_next  = 5'(1 << P_STATUS);
                    state_next = ST_EMIT;
                end
                else
                begin
                    s_we = 1'b1;
                    svalid_next[s_waddr] = 1'b1;
                    if (!hit_reg && !free_reg)
                    begin
                        svic_next = (svic_reg == SVIC_LAST) ? '0 : svic_reg + SIW'(1);
                    end
                    if (cur_reg.hdr.action == mfr_pkg::ACT_OWN)
                    begin
                        state_next = ST_EMIT;
                    end
                    else if (phase_reg == PH_FIRST)
                    begin
                        state_next = ST_ROUTE_SWEEP;
                    end
                    else if (phase_reg == PH_ACK && pend_reg[P_RELAY])
                    begin
                        key_next   = cur_reg.hdr.seq;
                        phase_next = PH_RELAY;
                        state_next = ST_SEEN_SWEEP;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_ROUTE_WR:
            begin
                r_we = 1'b1;
                rvalid_next[r_waddr] = 1'b1;
                if (!hit_reg && free_reg)
                begin
                    rcount_next = rcount_reg + RCW'(1);
                end
                if (!hit_reg && !free_reg)
                begin
                    rvic_next = (rvic_reg == RVIC_LAST) ? '0 : rvic_reg + RIW'(1);
                end
                if (pend_reg[P_ACK])
                begin
                    key_next   = lseq_reg;
                    oseq_next  = lseq_reg;
                    lseq_next  = lseq_reg + 32'd1;
                    phase_next = PH_ACK;
                    state_next = ST_SEEN_SWEEP;
                end
                else if (pend_reg[P_RELAY])
                begin
                    key_next   = cur_reg.hdr.seq;
                    phase_next = PH_RELAY;
                    state_next = ST_SEEN_SWEEP;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                res_new.source  = cur_reg.hdr.source;
                res_new.dest    = cur_reg.hdr.dest;
                res_new.seq     = cur_reg.hdr.seq;
                res_new.mtype   = cur_reg.hdr.mtype;
                res_new.prio    = cur_reg.hdr.prio;
                res_new.hops    = cur_reg.hdr.hops;
                res_new.ttl     = cur_reg.hdr.ttl;
                res_new.time_ms = cur_reg.hdr.ts;
                res_new.acked   = '0;
                res_is_last     = $onehot(pend_reg);
                if (pend_reg[P_DELIVER])
                begin
                    res_new.kind = mfr_pkg::KIND_DELIVER;
                    pend_next[P_DELIVER] = oq_full;
                end
                else if (pend_reg[P_ACK])
                begin
                    res_new.kind    = mfr_pkg::KIND_ACK;
                    res_new.source  = cfg.device_id;
                    res_new.dest    = cur_reg.hdr.source;
                    res_new.seq     = oseq_reg;
                    res_new.mtype   = mfr_pkg::TYPE_ACK;
                    res_new.prio    = cfg.ack_priority;
                    res_new.hops    = '0;
                    res_new.ttl     = mfr_pkg::ACK_TTL;
                    res_new.time_ms = now_reg;
                    res_new.acked   = cur_reg.hdr.seq;
                    pend_next[P_ACK] = oq_full;
                end
                else if (pend_reg[P_RELAY])
                begin
                    res_new.kind = mfr_pkg::KIND_RELAY;
                    res_new.hops = cur_reg.hdr.hops + 8'd1;
                    pend_next[P_RELAY] = oq_full;
                end
                else if (pend_reg[P_OWN])
                begin
                    res_new.kind    = mfr_pkg::KIND_OWN;
                    res_new.source  = cfg.device_id;
                    res_new.seq     = oseq_reg;
                    res_new.hops    = '0;
                    res_new.time_ms = now_reg;
                    pend_next[P_OWN] = oq_full;
                end
                else
                begin
                    res_new.kind = mfr_pkg::KIND_STATUS;
                    if (clean_reg)
                    begin
                        res_new = '0;
                        res_new.kind = mfr_pkg::KIND_STATUS;
                    end
                    pend_next[P_STATUS] = oq_full;
                end
                if (!oq_full)
                begin
                    oq_push = 1'b1;
                    if (res_is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign oq_din    = {rcount_reg, res_is_last, res_new};
    assign res_word  = oq_dout[RW-1:0];
    assign res_last  = oq_dout[RW];
    assign res_rc    = oq_dout[RW+RCW:RW+1];

    mfr_fifo #(
        .WIDTH (RW + RCW + 1),
        .DEPTH (mfr_pkg::OUTQ_DEPTH)
    ) u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (oq_push),
        .din   (oq_din),
        .full  (oq_full),
        .pop   (res_pop),
        .dout  (oq_dout),
        .empty (res_empty)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_FIRST;
            pend_reg   <= '0;
            clean_reg  <= 1'b0;
            lseq_reg   <= 32'd1;
            now_reg    <= '0;
            svalid_reg <= '0;
            rvalid_reg <= '0;
            rcount_reg <= '0;
            svic_reg   <= '0;
            rvic_reg   <= '0;
            cnt_reg    <= '0;
            chk_reg    <= 1'b0;
            hit_reg    <= 1'b0;
            free_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            pend_reg   <= pend_next;
            clean_reg  <= clean_next;
            lseq_reg   <= lseq_next;
            now_reg    <= now_next;
            svalid_reg <= svalid_next;
            rvalid_reg <= rvalid_next;
            rcount_reg <= rcount_next;
            svic_reg   <= svic_next;
            rvic_reg   <= rvic_next;
            cnt_reg    <= cnt_next;
            chk_reg    <= chk_next;
            hit_reg    <= hit_next;
            free_reg   <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_d_reg    <= idx_d_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        cur_reg      <= cur_next;
        key_reg      <= key_next;
        oseq_reg     <= oseq_next;
    end

    a_rcount: assert property (@(posedge clk) disable iff (!rst_n)
        rcount_reg == RCW'($countones(rvalid_reg)))
        else $error("route count out of step with valid bits");

    a_emit_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (pend_reg != '0))
        else $error("emit state with nothing pending");

    a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEEN_WR && hit_reg) |-> svalid_reg[hit_idx_reg[SIW-1:0]])
        else $error("seen hit on an invalid slot");

    a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUTE_SWEEP && chk_reg) |-> (idx_d_reg <= ROUTE_LAST))
        else $error("route sweep index past table end");

endmodule

@@ sv/mesh_flood_relay_filter.sv @@
// ----------------------------------------------------------------------------
// mesh_flood_relay_filter: flood routing duplicate suppression
// Seen-sequence filter, route learning and deliver/ack/relay decisions.
// ----------------------------------------------------------------------------
//  channel   | handshake           | word
//  ----------+---------------------+-------------------------------------------
//  input     | push / full         | action, header fields
//  result    | empty / pop         | kind, header out, acked_seq, route_count, last
//  config    | wr_en (no wait)     | wr_index, wr_data
//
//  A tick is handled as it is popped. Every other word is popped; then a
//  received header runs a seen-table sweep with its write, a route sweep
//  with its write, and up to two more seen sweeps for ack and relay, then
//  one to three result words; cleanup runs a route sweep, then a seen sweep,
//  then its status word. Each table RAM has a single read port, so one entry
//  is compared per cycle.
//  Reset clears valid bits at once; there is no clearing pass.
//  A full result queue stalls only the back end; the input queue keeps taking
//  words until it fills.
// ----------------------------------------------------------------------------
module mesh_flood_relay_filter #(
    parameter int SEEN_DEPTH  = mfr_pkg::SEEN_DEPTH_DEF,
    parameter int ROUTE_DEPTH = mfr_pkg::ROUTE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration
    input  logic                             wr_en,
    input  logic [1:0]                       wr_index,
    input  logic [31:0]                      wr_data,
    // input words
    input  logic                             push,
    output logic                             full,
    input  logic [1:0]                       action,
    input  logic [31:0]                      source_id,
    input  logic [31:0]                      dest_id,
    input  logic [31:0]                      seq,
    input  logic [7:0]                       msg_type,
    input  logic [1:0]                       priority_req,
    input  logic [7:0]                       hop_count,
    input  logic [7:0]                       ttl,
    input  logic [31:0]                      timestamp,
    // result words
    output logic                             empty,
    input  logic                             pop,
    output logic [2:0]                       kind,
    output logic [31:0]                      out_source,
    output logic [31:0]                      out_dest,
    output logic [31:0]                      out_seq,
    output logic [7:0]                       out_type,
    output logic [1:0]                       out_priority,
    output logic [7:0]                       out_hops,
    output logic [7:0]                       out_ttl,
    output logic [31:0]                      out_time,
    output logic [31:0]                      acked_seq,
    output logic [$clog2(ROUTE_DEPTH+1)-1:0] route_count,
    output logic                             last
);

    mfr_pkg::cfg_t  cfg_reg, cfg_next;
    mfr_pkg::hdr_t  hdr;
    mfr_pkg::item_t q_item;
    mfr_pkg::res_t  res_word;
    logic           q_pop, q_empty;

    // register file: writes land directly, all four indexes defined
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (mfr_pkg::reg_idx_t'(wr_index))
                mfr_pkg::REG_DEVICE_ID:    cfg_next.device_id    = wr_data;
                mfr_pkg::REG_MAX_HOPS:     cfg_next.max_hops     = wr_data[7:0];
                mfr_pkg::REG_MAX_AGE_MS:   cfg_next.max_age_ms   = wr_data;
                mfr_pkg::REG_ACK_PRIORITY: cfg_next.ack_priority = wr_data[1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.device_id    <= mfr_pkg::DEVICE_ID_RST;
            cfg_reg.max_hops     <= mfr_pkg::MAX_HOPS_RST;
            cfg_reg.max_age_ms   <= mfr_pkg::MAX_AGE_MS_RST;
            cfg_reg.ack_priority <= mfr_pkg::ACK_PRIORITY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign hdr.action = mfr_pkg::action_t'(action);
    assign hdr.source = source_id;
    assign hdr.dest   = dest_id;
    assign hdr.seq    = seq;
    assign hdr.mtype  = msg_type;
    assign hdr.prio   = priority_req;
    assign hdr.hops   = hop_count;
    assign hdr.ttl    = ttl;
    assign hdr.ts     = timestamp;

    // front: classify and queue
    mfr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .push    (push),
        .hdr     (hdr),
        .full    (full),
        .q_pop   (q_pop),
        .q_item  (q_item),
        .q_empty (q_empty)
    );

    // back: table sweeps, updates and result queue
    mfr_back #(
        .SEEN_DEPTH  (SEEN_DEPTH),
        .ROUTE_DEPTH (ROUTE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_item    (q_item),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .res_pop   (pop),
        .res_empty (empty),
        .res_word  (res_word),
        .res_rc    (route_count),
        .res_last  (last)
    );

    assign kind         = res_word.kind;
    assign out_source   = res_word.source;
    assign out_dest     = res_word.dest;
    assign out_seq      = res_word.seq;
    assign out_type     = res_word.mtype;
    assign out_priority = res_word.prio;
    assign out_hops     = res_word.hops;
    assign out_ttl      = res_word.ttl;
    assign out_time     = res_word.time_ms;
    assign acked_seq    = res_word.acked;

endmodule

@@ test/tb_mesh_flood_relay_filter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mesh_flood_relay_filter: self-checking bench for the flood relay filter
// Drives headers, own sends, ticks and sweeps through the input queue, keeps a
// cycle-free copy of the seen and route tables, and compares every result word.
// ----------------------------------------------------------------------------
module tb_mesh_flood_relay_filter;

    localparam int SEEN_N  = mfr_pkg::SEEN_DEPTH_DEF;
    localparam int ROUTE_N = mfr_pkg::ROUTE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 900000;
    // settle time after the last result, for trailing queued ticks
    localparam int DRAIN_CYCLES = 40;

    // expected result word
    typedef struct {
        mfr_pkg::kind_t kind;
        logic [31:0] source;
        logic [31:0] dest;
        logic [31:0] seq;
        logic [7:0]  mtype;
        logic [1:0]  prio;
        logic [7:0]  hops;
        logic [7:0]  ttl;
        logic [31:0] time_ms;
        logic [31:0] acked;
        logic [5:0]  routes;
        logic        last;
    } res_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        wr_en = 1'b0;
    logic [1:0]  wr_index = '0;
    logic [31:0] wr_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  action = '0;
    logic [31:0] source_id = '0;
    logic [31:0] dest_id = '0;
    logic [31:0] seq = '0;
    logic [7:0]  msg_type = '0;
    logic [1:0]  priority_req = '0;
    logic [7:0]  hop_count = '0;
    logic [7:0]  ttl = '0;
    logic [31:0] timestamp = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  kind;
    logic [31:0] out_source, out_dest, out_seq, out_time, acked_seq;
    logic [7:0]  out_type, out_hops, out_ttl;
    logic [1:0]  out_priority;
    logic [5:0]  route_count;
    logic        last;

    mesh_flood_relay_filter dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---- shadow state of the block ----
    logic [31:0] my_id, age_limit;
    logic [7:0]  hop_limit;
    logic [1:0]  ack_prio;
    logic [31:0] seen_seq_t[SEEN_N], seen_time_t[SEEN_N];
    bit          seen_ok[SEEN_N];
    logic [31:0] rt_node[ROUTE_N], rt_time[ROUTE_N];
    bit          rt_ok[ROUTE_N];
    logic [31:0] next_seq, clock_ms;
    int          seen_ptr, rt_ptr;

    res_word_t   pending_words[$];
    logic [31:0] used_seqs[$];     // pool for duplicate stimulus
    int          errors = 0;
    int          words_checked = 0;
    int          items_sent = 0;
    int          cycles = 0;

    function automatic void note_seen(logic [31:0] s);
        int i;
        for (i = 0; i < SEEN_N; i++)
            if (seen_ok[i] && seen_seq_t[i] == s)
            begin
                seen_time_t[i] = clock_ms;
                return;
            end
        for (i = 0; i < SEEN_N; i++)
            if (!seen_ok[i]) break;
        if (i == SEEN_N)
        begin
            i = seen_ptr;
            seen_ptr = (seen_ptr + 1) % SEEN_N;
        end
        seen_ok[i] = 1; seen_seq_t[i] = s; seen_time_t[i] = clock_ms;
    endfunction

    function automatic bit already_seen(logic [31:0] s);
        for (int i = 0; i < SEEN_N; i++)
            if (seen_ok[i] && seen_seq_t[i] == s) return 1;
        return 0;
    endfunction

    function automatic void learn_route(logic [31:0] node);
        int i;
        for (i = 0; i < ROUTE_N; i++)
            if (rt_ok[i] && rt_node[i] == node) break;
        if (i == ROUTE_N)
        begin
            for (i = 0; i < ROUTE_N; i++)
                if (!rt_ok[i]) break;
            if (i == ROUTE_N)
            begin
                i = rt_ptr;
                rt_ptr = (rt_ptr + 1) % ROUTE_N;
            end
        end
        rt_ok[i] = 1; rt_node[i] = node; rt_time[i] = clock_ms;
    endfunction

    function automatic res_word_t mk(mfr_pkg::kind_t k, logic [31:0] src,
                                     logic [31:0] dst, logic [31:0] sq, logic [7:0] ty,
                                     logic [1:0] pr, logic [7:0] hp, logic [7:0] tl,
                                     logic [31:0] tm, logic [31:0] ak);
        res_word_t w;
        w.kind = k; w.source = src; w.dest = dst; w.seq = sq; w.mtype = ty;
        w.prio = pr; w.hops = hp; w.ttl = tl; w.time_ms = tm; w.acked = ak;
        w.routes = '0; w.last = 1'b0;
        return w;
    endfunction

    // Works out the words one accepted input causes and queues them.
    function automatic void predict_words(mfr_pkg::hdr_t h);
        res_word_t w[$];
        logic [31:0] s;
        int n;
        bit relay;
        if (h.action == mfr_pkg::ACT_TICK)
        begin
            clock_ms++;
            return;
        end
        if (h.action == mfr_pkg::ACT_CLEAN)
        begin
            for (int i = 0; i < ROUTE_N; i++)
                if (rt_ok[i] && (clock_ms - rt_time[i]) > age_limit) rt_ok[i] = 0;
            for (int i = 0; i < SEEN_N; i++)
                if (seen_ok[i] && (clock_ms - seen_time_t[i]) > age_limit) seen_ok[i] = 0;
            w.push_back(mk(mfr_pkg::KIND_STATUS, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        end
        else if (h.action == mfr_pkg::ACT_OWN)
        begin
            s = next_seq++;
            note_seen(s);
            w.push_back(mk(mfr_pkg::KIND_OWN, my_id, h.dest, s, h.mtype, h.prio, 8'd0,
                           h.ttl, clock_ms, 32'd0));
        end
        else if (already_seen(h.seq))
            w.push_back(mk(mfr_pkg::KIND_STATUS, h.source, h.dest, h.seq, h.mtype, h.prio,
                           h.hops, h.ttl, h.ts, 32'd0));
        else
        begin
            note_seen(h.seq);
            learn_route(h.source);
            if (h.dest == my_id || h.dest == mfr_pkg::BROADCAST_ID)
            begin
                w.push_back(mk(mfr_pkg::KIND_DELIVER, h.source, h.dest, h.seq, h.mtype,
                               h.prio, h.hops, h.ttl, h.ts, 32'd0));
                if (h.dest != mfr_pkg::BROADCAST_ID)
                begin
                    s = next_seq++;
                    note_seen(s);
                    w.push_back(mk(mfr_pkg::KIND_ACK, my_id, h.source, s, mfr_pkg::TYPE_ACK,
                                   ack_prio, 8'd0, mfr_pkg::ACK_TTL, clock_ms, h.seq));
                end
            end
            relay = 1;
            if (h.hops >= hop_limit) relay = 0;
            else if ((clock_ms - h.ts) / mfr_pkg::MS_PER_S > h.ttl) relay = 0;
            else if (h.mtype == mfr_pkg::TYPE_ACK || h.mtype == mfr_pkg::TYPE_NACK)
                relay = 0;
            else if (h.dest != mfr_pkg::BROADCAST_ID && h.dest != my_id) relay = 0;
            if (relay)
            begin
                note_seen(h.seq);
                w.push_back(mk(mfr_pkg::KIND_RELAY, h.source, h.dest, h.seq, h.mtype,
                               h.prio, h.hops + 8'd1, h.ttl, h.ts, 32'd0));
            end
            if (w.size() == 0)
                w.push_back(mk(mfr_pkg::KIND_STATUS, h.source, h.dest, h.seq, h.mtype,
                               h.prio, h.hops, h.ttl, h.ts, 32'd0));
        end
        n = 0;
        foreach (rt_ok[i]) n += rt_ok[i];
        foreach (w[i])
        begin
            w[i].routes = n[5:0];
            w[i].last = (i == w.size() - 1);
            pending_words.push_back(w[i]);
        end
    endfunction

    // ---- sender ----
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Called right after a rising edge; push stays high when the next word follows.
    task automatic send_word(mfr_pkg::hdr_t h);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        action <= h.action; source_id <= h.source; dest_id <= h.dest; seq <= h.seq;
        msg_type <= h.mtype; priority_req <= h.prio; hop_count <= h.hops;
        ttl <= h.ttl; timestamp <= h.ts;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_words(h);
        items_sent++;
        if (h.action == mfr_pkg::ACT_RECV) used_seqs.push_back(h.seq);
    endtask

    // Wait for every queued word, plus slack for trailing ticks.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pending_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One write, then wr_en low again so back-to-back writes never clash on wr_en.
    task automatic write_reg(mfr_pkg::reg_idx_t idx, logic [31:0] value);
        wr_en <= 1'b1; wr_index <= idx; wr_data <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            mfr_pkg::REG_DEVICE_ID:    my_id = value;
            mfr_pkg::REG_MAX_HOPS:     hop_limit = value[7:0];
            mfr_pkg::REG_MAX_AGE_MS:   age_limit = value;
            mfr_pkg::REG_ACK_PRIORITY: ack_prio = value[1:0];
            default:                   ;
        endcase
    endtask

    function automatic mfr_pkg::hdr_t recv_hdr(logic [31:0] src, logic [31:0] dst,
                                               logic [31:0] sq, logic [7:0] ty,
                                               logic [7:0] hp, logic [7:0] tl,
                                               logic [31:0] ts);
        mfr_pkg::hdr_t h;
        h.action = mfr_pkg::ACT_RECV; h.source = src; h.dest = dst; h.seq = sq;
        h.mtype = ty; h.prio = 2'($urandom_range(0, 3)); h.hops = hp; h.ttl = tl;
        h.ts = ts;
        return h;
    endfunction

    function automatic mfr_pkg::hdr_t ctl_hdr(mfr_pkg::action_t a);
        mfr_pkg::hdr_t h;
        h = recv_hdr($urandom, $urandom, $urandom, 8'($urandom), 8'($urandom),
                     8'($urandom), $urandom);
        h.action = a;
        return h;
    endfunction

    function automatic void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    function automatic void check_word();
        res_word_t e;
        if (pending_words.size() == 0)
        begin
            $display("%0t ns: unexpected result word, kind %0d seq %0h", $time, kind, out_seq);
            errors++;
            return;
        end
        e = pending_words.pop_front();
        words_checked++;
        cmp("kind", 32'(e.kind), 32'(kind));
        cmp("out_source", e.source, out_source);
        cmp("out_dest", e.dest, out_dest);
        cmp("out_seq", e.seq, out_seq);
        cmp("out_type", 32'(e.mtype), 32'(out_type));
        cmp("out_priority", 32'(e.prio), 32'(out_priority));
        cmp("out_hops", 32'(e.hops), 32'(out_hops));
        cmp("out_ttl", 32'(e.ttl), 32'(out_ttl));
        cmp("out_time", e.time_ms, out_time);
        cmp("acked_seq", e.acked, acked_seq);
        cmp("route_count", 32'(e.routes), 32'(route_count));
        cmp("last", 32'(e.last), 32'(last));
    endfunction

    // ---- result side: random stalls, short mostly, some long ----
    int stall_left = 0;
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            check_word();
        if (stall_left > 0)
        begin
            stall_left--;
            pop <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 25)
        begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                     : $urandom_range(1, 3);
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycles, pending_words.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---- tests ----

    // Defaults after reset, then every special case once.
    task automatic test_directed();
        logic [31:0] base;
        send_word(recv_hdr(32'h0, 32'h0, 32'h10, 8'd9, 8'd0, 8'd5, 32'h0));  // ack at id 0
        wait_idle();
        write_reg(mfr_pkg::REG_DEVICE_ID, 32'h1234_5678);
        write_reg(mfr_pkg::REG_ACK_PRIORITY, 32'd3);
        repeat (5) send_word(ctl_hdr(mfr_pkg::ACT_TICK));
        send_word(recv_hdr(32'hAAAA_0001, mfr_pkg::BROADCAST_ID, 32'h20, 8'd0, 8'd0, 8'd10,
                           32'd0));
        send_word(recv_hdr(32'hAAAA_0002, 32'h1234_5678, 32'h21, 8'd1, 8'd1, 8'd10, 32'd0));
        send_word(recv_hdr(32'hAAAA_0003, 32'h5555_5555, 32'h22, 8'd4, 8'd0, 8'd10, 32'd0));
        send_word(recv_hdr(32'hAAAA_0004, mfr_pkg::BROADCAST_ID, 32'h23, mfr_pkg::TYPE_ACK,
                           8'd0, 8'd9, 32'd0));
        send_word(recv_hdr(32'hAAAA_0005, mfr_pkg::BROADCAST_ID, 32'h24, mfr_pkg::TYPE_NACK,
                           8'd0, 8'd9, 32'd0));
        send_word(recv_hdr(32'hAAAA_0006, mfr_pkg::BROADCAST_ID, 32'h25, 8'hFF, 8'd5, 8'd9,
                           32'd0));
        send_word(recv_hdr(32'hAAAA_0007, mfr_pkg::BROADCAST_ID, 32'h26, 8'd0, 8'd4, 8'd9,
                           32'd0));
        // stale by ttl: age 3000 ms against ttl 2 versus exactly at the limit
        base = 32'd5 - 32'd3000;
        send_word(recv_hdr(32'hAAAA_0008, mfr_pkg::BROADCAST_ID, 32'h27, 8'd0, 8'd0, 8'd2,
                           base));
        send_word(recv_hdr(32'hAAAA_0008, mfr_pkg::BROADCAST_ID, 32'h28, 8'd0, 8'd0, 8'd3,
                           base));
        // timestamp in the future wraps to a huge age
        send_word(recv_hdr(32'hAAAA_0009, mfr_pkg::BROADCAST_ID, 32'h29, 8'd0, 8'd0, 8'hFF,
                           32'd100));
        // duplicate, and all-ones fields
        send_word(recv_hdr(32'hAAAA_0001, mfr_pkg::BROADCAST_ID, 32'h20, 8'd0, 8'd0, 8'd10,
                           32'd0));
        send_word(recv_hdr(32'hFFFF_FFFF, mfr_pkg::BROADCAST_ID, 32'hFFFF_FFFF, 8'hFF, 8'hFF,
                           8'hFF, 32'hFFFF_FFFF));
        send_word(ctl_hdr(mfr_pkg::ACT_OWN));
        send_word(ctl_hdr(mfr_pkg::ACT_CLEAN));
        wait_idle();
        // device id equal to broadcast: delivered, no ack
        write_reg(mfr_pkg::REG_DEVICE_ID, mfr_pkg::BROADCAST_ID);
        send_word(recv_hdr(32'hBBBB_0001, mfr_pkg::BROADCAST_ID, 32'h30, 8'd0, 8'd0, 8'd9,
                           32'd0));
        send_word(ctl_hdr(mfr_pkg::ACT_OWN));
        wait_idle();
    endtask

    // Overflow both tables so the round-robin pointers wrap.
    task automatic test_table_fill();
        write_reg(mfr_pkg::REG_DEVICE_ID, 32'h0000_0042);
        write_reg(mfr_pkg::REG_MAX_HOPS, 32'd0);
        for (int i = 0; i < 40; i++)
            send_word(recv_hdr(32'hC000_0000 + i, 32'h7777_0000, 32'h5000_0000 + i,
                               8'd0, 8'($urandom), 8'd9, 32'd0));
        for (int i = 0; i < 35; i++)
            send_word(ctl_hdr(mfr_pkg::ACT_OWN));
        // oldest sequences were evicted, so they pass again
        for (int i = 0; i < 4; i++)
            send_word(recv_hdr(32'hC000_0000 + i, 32'h0000_0042, 32'h5000_0000 + i,
                               8'd0, 8'd0, 8'd9, 32'd0));
        wait_idle();
    endtask

    // Sweeps with age limit zero, then the widest limit.
    task automatic test_aging();
        write_reg(mfr_pkg::REG_MAX_AGE_MS, 32'd0);
        write_reg(mfr_pkg::REG_MAX_HOPS, 32'hFF);
        send_word(recv_hdr(32'hD000_0001, mfr_pkg::BROADCAST_ID, 32'h6000_0001, 8'd0, 8'd1,
                           8'd9, clock_ms));
        send_word(ctl_hdr(mfr_pkg::ACT_CLEAN));     // same ms: nothing ages out
        send_word(ctl_hdr(mfr_pkg::ACT_TICK));
        send_word(ctl_hdr(mfr_pkg::ACT_TICK));
        send_word(ctl_hdr(mfr_pkg::ACT_CLEAN));     // everything goes
        send_word(recv_hdr(32'hD000_0001, mfr_pkg::BROADCAST_ID, 32'h6000_0001, 8'd0, 8'd1,
                           8'd9, clock_ms));
        wait_idle();
        write_reg(mfr_pkg::REG_MAX_AGE_MS, 32'hFFFF_FFFF);
        send_word(ctl_hdr(mfr_pkg::ACT_TICK));
        send_word(ctl_hdr(mfr_pkg::ACT_CLEAN));
        wait_idle();
    endtask

    // Mostly plausible traffic with random content; a share of noise.
    task automatic test_random(int count);
        mfr_pkg::hdr_t h;
        int r;
        logic [31:0] dst;
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                wait_idle();
                write_reg(mfr_pkg::REG_DEVICE_ID, ($urandom_range(0, 3) == 0) ? $urandom
                                                                       : 32'h0000_0100);
                write_reg(mfr_pkg::REG_MAX_HOPS, ($urandom_range(0, 4) == 0) ? $urandom
                                                                      : $urandom_range(1, 8));
                write_reg(mfr_pkg::REG_ACK_PRIORITY, $urandom_range(0, 3));
                write_reg(mfr_pkg::REG_MAX_AGE_MS, $urandom_range(0, 3) == 0 ? $urandom
                                                                      : $urandom_range(0, 20));
            end
            r = $urandom_range(0, 99);
            if (r < 8)
                h = ctl_hdr(mfr_pkg::ACT_TICK);
            else if (r < 12)
                h = ctl_hdr(mfr_pkg::ACT_CLEAN);
            else if (r < 22)
                h = ctl_hdr(mfr_pkg::ACT_OWN);
            else
            begin
                case ($urandom_range(0, 3))
                    0: dst = mfr_pkg::BROADCAST_ID;
                    1: dst = my_id;
                    2: dst = $urandom;
                    default: dst = 32'h0000_0100 + $urandom_range(0, 2);
                endcase
                h = recv_hdr(($urandom_range(0, 1) ? $urandom : 32'hE000_0000
                              + $urandom_range(0, 40)),
                             dst, $urandom, 8'($urandom_range(0, 5)),
                             8'($urandom_range(0, 10)), 8'($urandom_range(0, 4)),
                             clock_ms - $urandom_range(0, 5000));
                if (r < 30) h.mtype = 8'($urandom);
                if (r < 34) { h.hops, h.ttl, h.ts } = { 16'($urandom), $urandom };
                if (r >= 85 && used_seqs.size() > 0)
                    h.seq = used_seqs[$urandom_range(0, used_seqs.size() - 1)];
            end
            send_word(h);
        end
        wait_idle();
    endtask

    initial
    begin
        my_id = mfr_pkg::DEVICE_ID_RST; hop_limit = mfr_pkg::MAX_HOPS_RST;
        age_limit = mfr_pkg::MAX_AGE_MS_RST; ack_prio = mfr_pkg::ACK_PRIORITY_RST;
        foreach (seen_ok[i]) seen_ok[i] = 0;
        foreach (rt_ok[i]) rt_ok[i] = 0;
        next_seq = 32'd1; clock_ms = 0; seen_ptr = 0; rt_ptr = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_fill();
        test_aging();
        test_random(40);

        $display("ran %0d input words, checked %0d result words over %0d cycles",
                 items_sent, words_checked, cycles);
        $display("covered deliver, ack, relay, own send, duplicates, table wrap and aging");
        if (errors == 0 && pending_words.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
